@@ sv/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with active low reset
`define I2A_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("i2a assertion failed");

// condition that must never hold on a clock edge
`define I2A_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("i2a forbidden condition seen");

`endif

@@ sv/i2a_pkg.sv @@
`default_nettype none
package i2a_pkg;

  // format codes
  localparam logic [1:0] ACT_DEC    = 2'd0;
  localparam logic [1:0] ACT_HEX_LO = 2'd1;
  localparam logic [1:0] ACT_HEX_UP = 2'd2;
  localparam logic [1:0] ACT_PTR    = 2'd3;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 5;
  localparam int unsigned BinW   = 32;
  localparam int unsigned DecDigits = 10;

  localparam logic [CharW-1:0] CHR_ZERO = 8'h30;
  localparam logic [CharW-1:0] CHR_X    = 8'h78;
  localparam logic [CharW-1:0] CHR_LO_A = 8'h61;
  localparam logic [CharW-1:0] CHR_UP_A = 8'h41;

  // character source for the output
  typedef enum logic [1:0] {
    CH_DIGIT,
    CH_ZERO,
    CH_X
  } chsel_e;

  // controller to datapath
  typedef struct packed {
    logic   load;
    logic   conv;
    logic   shift;
    logic   set_total;
    chsel_e sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic ndig_one;
    logic is_ptr;
  } sts_t;

  // one nibble to its ascii digit
  function automatic logic [CharW-1:0] digit_char(input logic [3:0] n, input logic upper);
    logic [CharW-1:0] n8;
    n8 = {4'h0, n};
    if (n < 4'd10) begin
      digit_char = CHR_ZERO + n8;
    end else if (upper) begin
      digit_char = CHR_UP_A + n8 - 8'd10;
    end else begin
      digit_char = CHR_LO_A + n8 - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/integer_to_ascii_formatter_unit.sv @@
// integer to ascii formatter: one request in, one character per cycle out while the receiver is ready
// hex and pointer: a load, a skip of up to N - 1 leading zero digits, then d (+2) chars
// decimal adds a shift-add-3 conversion of the low 32 bits, one value bit per cycle, before the skip
// N is 8 for hex, 16 for pointer, 10 for decimal; d is the printed digit count
// one request at a time: a new one is taken only once the last character of a text is out
// rst_ni asynchronous active low: idle, ready for a request, no output pending
`default_nettype none
module integer_to_ascii_formatter_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  action_i,
  input  wire logic [i2a_pkg::ValueW-1:0]  value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [i2a_pkg::CharW-1:0]        character_o,
  output logic                             last_o,
  output logic [i2a_pkg::CountW-1:0]       char_count_o
);
  import i2a_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  i2a_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // digit buffer and conversion
  i2a_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (action_i),
    .value_i      (value_i),
    .sts_o        (sts),
    .character_o  (character_o),
    .last_o       (last_o),
    .char_count_o (char_count_o)
  );

endmodule
`default_nettype wire

@@ sv/i2a_dpath.sv @@
`default_nettype none
module i2a_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire i2a_pkg::cmd_t               cmd_i,
  input  wire logic [1:0]                  action_i,
  input  wire logic [i2a_pkg::ValueW-1:0]  value_i,
  output i2a_pkg::sts_t                    sts_o,
  output logic [i2a_pkg::CharW-1:0]        character_o,
  output logic                             last_o,
  output logic [i2a_pkg::CountW-1:0]       char_count_o
);
  import i2a_pkg::*;

  localparam int unsigned BcdLo = ValueW - 4 * DecDigits;

  logic [ValueW-1:0] dig_q, dig_d;
  logic [BinW-1:0]   bin_q, bin_d;
  logic [4:0]        bit_cnt_q, bit_cnt_d;
  logic [CountW-1:0] ndig_q, ndig_d;
  logic [CountW-1:0] total_q, total_d;
  logic              upper_q, upper_d;
  logic              ptr_q, ptr_d;
  logic [4*DecDigits-1:0] bcd_adj;

  // add 3 to every bcd digit of five or more
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      logic [3:0] d;
      d = dig_q[BcdLo + 4*i +: 4];
      bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  // next state of the digit buffer and counters
  always_comb begin
    dig_d     = dig_q;
    bin_d     = bin_q;
    bit_cnt_d = bit_cnt_q;
    ndig_d    = ndig_q;
    total_d   = total_q;
    upper_d   = upper_q;
    ptr_d     = ptr_q;
    if (cmd_i.load) begin
      bin_d     = value_i[BinW-1:0];
      bit_cnt_d = '0;
      upper_d   = (action_i == ACT_HEX_UP);
      ptr_d     = (action_i == ACT_PTR);
      case (action_i)
        ACT_DEC: begin
          dig_d  = '0;
          ndig_d = CountW'(DecDigits);
        end
        ACT_PTR: begin
          dig_d  = value_i;
          ndig_d = CountW'(16);
        end
        default: begin
          dig_d  = {value_i[BinW-1:0], {(ValueW-BinW){1'b0}}};
          ndig_d = CountW'(8);
        end
      endcase
    end else if (cmd_i.conv) begin
      dig_d     = {bcd_adj[4*DecDigits-2:0], bin_q[BinW-1], {BcdLo{1'b0}}};
      bin_d     = {bin_q[BinW-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q + 5'd1;
    end else if (cmd_i.shift) begin
      dig_d  = {dig_q[ValueW-5:0], 4'h0};
      ndig_d = ndig_q - CountW'(1);
    end
    if (cmd_i.set_total) begin
      total_d = ndig_q + (ptr_q ? CountW'(2) : CountW'(0));
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      ndig_q    <= CountW'(1);
    end else begin
      bit_cnt_q <= bit_cnt_d;
      ndig_q    <= ndig_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    bin_q   <= bin_d;
    total_q <= total_d;
    upper_q <= upper_d;
    ptr_q   <= ptr_d;
  end

  // status
  assign sts_o.conv_done = (bit_cnt_q == 5'd31);
  assign sts_o.top_zero  = (dig_q[ValueW-1 -: 4] == 4'h0);
  assign sts_o.ndig_one  = (ndig_q == CountW'(1));
  assign sts_o.is_ptr    = ptr_q;

  // output character
  always_comb begin
    case (cmd_i.sel)
      CH_ZERO: character_o = CHR_ZERO;
      CH_X:    character_o = CHR_X;
      default: character_o = digit_char(dig_q[ValueW-1 -: 4], upper_q);
    endcase
  end

  assign last_o       = (cmd_i.sel == CH_DIGIT) && (ndig_q == CountW'(1));
  assign char_count_o = last_o ? total_q : '0;

endmodule
`default_nettype wire

@@ sv/i2a_ctrl.sv @@
`default_nettype none
module i2a_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    action_i,
  input  wire logic          out_ready_i,
  input  wire i2a_pkg::sts_t sts_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output i2a_pkg::cmd_t      cmd_o
);
  import i2a_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PRE0,
    ST_PRE1,
    ST_DIGIT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, out_valid_q;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.sel     = CH_DIGIT;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (action_i == ACT_DEC) ? ST_CONV : ST_SKIP;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (sts_i.conv_done) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if (sts_i.top_zero && !sts_i.ndig_one) begin
          cmd_o.shift = 1'b1;
        end else begin
          cmd_o.set_total = 1'b1;
          state_d = sts_i.is_ptr ? ST_PRE0 : ST_DIGIT;
        end
      end
      ST_PRE0: begin
        cmd_o.sel = CH_ZERO;
        if (out_ready_i) state_d = ST_PRE1;
      end
      ST_PRE1: begin
        cmd_o.sel = CH_X;
        if (out_ready_i) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_ready_i) begin
          cmd_o.shift = 1'b1;
          if (sts_i.ndig_one) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= (state_d == ST_IDLE);
      out_valid_q <= (state_d == ST_PRE0) || (state_d == ST_PRE1) ||
                     (state_d == ST_DIGIT);
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ sv/i2a_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module i2a_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [i2a_pkg::CharW-1:0]   character_o,
  input wire logic                        last_o,
  input wire logic [i2a_pkg::CountW-1:0]  char_count_o
);
  import i2a_pkg::*;

  logic           out_stall;
  logic [CharW:0] out_char;
  logic           count_ok;
  logic           last_acc;

  // helper terms for the properties below
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_char  = {character_o, last_o};
  assign count_ok  = last_o ? (char_count_o != '0 && char_count_o <= CountW'(18)) :
                              (char_count_o == '0);
  assign last_acc  = out_valid_o && out_ready_i && last_o;

  // stalled character holds
  `I2A_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_char))
  // one request at a time: no new request while text is going out
  `I2A_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o)
  // accepted request closes the input side
  `I2A_ASSERT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  // count shown only on the final character and within range
  `I2A_ASSERT(a_count_range, clk_i, rst_ni, out_valid_o |-> count_ok)
  // after the final character the block is ready again
  `I2A_ASSERT(a_ready_after_last, clk_i, rst_ni, last_acc |=> in_ready_o && !out_valid_o)

endmodule

bind integer_to_ascii_formatter_unit i2a_checker u_i2a_checker (.*);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import i2a_pkg::*;

  localparam int unsigned DrainCycles = 64;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomItems = 500;

  // one expected character of the formatted text
  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic              last;
    logic [CountW-1:0] count;
  } text_char_t;

  // receiver behavior for one stretch of cycles
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_SPARSE,
    RDY_PATTERN
  } stall_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          action_i = ACT_DEC;
  logic [ValueW-1:0]   value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CharW-1:0]    character_o;
  logic                last_o;
  logic [CountW-1:0]   char_count_o;

  text_char_t  text_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  stall_mode_e stall_mode = RDY_ALWAYS;
  int unsigned stall_left = 0;
  logic [7:0]  stall_mask = 8'hff;

  integer_to_ascii_formatter_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o),
    .char_count_o(char_count_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls, switching behavior every stretch
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(32, 200);
      stall_mask = 8'($urandom) | 8'h01;
    end else begin
      stall_left--;
    end
    case (stall_mode)
      RDY_ALWAYS: out_ready_i <= 1'b1;
      RDY_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: begin
        out_ready_i <= stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[7:1]};
      end
    endcase
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // expected text of one request, one entry per character
  function automatic void predict_text(input logic [1:0] act, input logic [ValueW-1:0] val);
    string             lo = "0123456789abcdef";
    string             up = "0123456789ABCDEF";
    logic [CharW-1:0]  digits[16];
    int                nd;
    int                pre;
    int                total;
    logic [ValueW-1:0] v;
    text_char_t        c;
    nd  = 0;
    pre = 0;
    v   = val;
    // only pointer mode looks at the upper word
    if (act != ACT_PTR) v = {32'd0, val[31:0]};
    if (act == ACT_DEC) begin
      do begin
        digits[nd] = lo[v % 10];
        v = v / 10;
        nd++;
      end while (v != 0);
    end else begin
      do begin
        digits[nd] = (act == ACT_HEX_UP) ? up[v[3:0]] : lo[v[3:0]];
        v = v >> 4;
        nd++;
      end while (v != 0);
      if (act == ACT_PTR) pre = 2;
    end
    total = pre + nd;
    if (pre != 0) begin
      c.ch = "0";
      c.last = 1'b0;
      c.count = '0;
      text_q.push_back(c);
      c.ch = "x";
      text_q.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.ch    = digits[i];
      c.last  = (i == 0);
      c.count = (i == 0) ? CountW'(total) : '0;
      text_q.push_back(c);
    end
  endfunction

  // compare each accepted character with the oldest expectation
  always @(posedge clk_i) begin
    text_char_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (text_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character 8'h%02h", character_o));
      end else begin
        e = text_q.pop_front();
        if (character_o !== e.ch)
          report_mismatch($sformatf("character 8'h%02h, expected 8'h%02h", character_o, e.ch));
        if (last_o !== e.last)
          report_mismatch($sformatf("last %b, expected %b", last_o, e.last));
        if (char_count_o !== e.count)
          report_mismatch($sformatf("char_count %0d, expected %0d", char_count_o, e.count));
      end
    end
  end

  // send one request; called and returns at a falling edge
  task automatic send_request(input logic [1:0] act, input logic [ValueW-1:0] val);
    int unsigned gap;
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_text(act, val);
    @(negedge clk_i);
    // bursts of back to back requests with random gaps between them
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  // stop sending and wait for every expected character
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (text_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [ValueW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_zero_values();
    send_request(ACT_DEC, '0);
    send_request(ACT_HEX_LO, '0);
    send_request(ACT_HEX_UP, '0);
    send_request(ACT_PTR, '0);
  endtask

  task automatic test_longest_texts();
    send_request(ACT_DEC, 64'h0000_0000_ffff_ffff);
    send_request(ACT_HEX_LO, 64'h0000_0000_ffff_ffff);
    send_request(ACT_HEX_UP, 64'h0000_0000_ffff_ffff);
    send_request(ACT_PTR, 64'hffff_ffff_ffff_ffff);
    send_request(ACT_PTR, 64'h8000_0000_0000_0000);
    send_request(ACT_DEC, 64'd1_000_000_000);
  endtask

  task automatic test_upper_bits_ignored();
    send_request(ACT_DEC, 64'hffff_ffff_0000_0000);
    send_request(ACT_HEX_LO, 64'h1234_5678_9abc_def0);
    send_request(ACT_HEX_UP, 64'h1234_5678_9abc_def0);
    send_request(ACT_DEC, 64'h8000_0000_0000_000a);
  endtask

  task automatic test_digit_edges();
    send_request(ACT_DEC, 64'd9);
    send_request(ACT_DEC, 64'd10);
    send_request(ACT_HEX_LO, 64'h0000_0000_0000_000a);
    send_request(ACT_HEX_UP, 64'h0000_0000_0000_00f0);
    send_request(ACT_PTR, 64'h0000_0001_0000_0000);
    send_request(ACT_PTR, 64'h0000_0000_0000_00ab);
  endtask

  // random requests, with a full drain now and then
  task automatic test_random_requests();
    logic [1:0]        act;
    logic [ValueW-1:0] val;
    for (int n = 0; n < RandomItems; n++) begin
      act = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1:       val = 64'($urandom_range(0, 20)) | (rand64() & {32'hffff_ffff, 32'd0});
        2, 3, 4, 5: val = rand64() >> $urandom_range(0, 63);
        6, 7, 8:    val = rand64();
        default:    val = 64'd1 << $urandom_range(0, 63);
      endcase
      send_request(act, val);
      if (n % 125 == 124) drain_requests();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_zero_values();
    test_longest_texts();
    drain_requests();
    test_upper_bits_ignored();
    test_digit_edges();
    drain_requests();
    test_random_requests();
    drain_requests();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
